// File: sv/csn_pkg.sv
`timescale 1ns / 1ps
// shared types, widths, codes and saturation helpers for the cumulative simpson core
// no dependencies

package csn_pkg;

  localparam int XW   = 32;   // abscissa and sample width
  localparam int IDXW = 16;   // point index width
  localparam int IW   = 64;   // integral width
  localparam int STW  = 2;    // status width
  localparam int MW   = 33;   // multiplier operand width
  localparam int PW   = 2 * MW;
  localparam int CW   = 97;   // coefficient width, holds +-2^95
  localparam int AW   = 128;  // wide accumulator width
  localparam int DIV_NW = 100; // dividend magnitude bits
  localparam int DIV_DW = 37;  // divisor magnitude bits

  localparam int MAX_POINTS_DEF = 65536;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [STW-1:0] STAT_OK    = 2'd0;
  localparam logic [STW-1:0] STAT_SHORT = 2'd1;
  localparam logic [STW-1:0] STAT_ZERO  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SPC, S_M_DD, S_M_DH, S_NUM,
    S_DIVA, S_WAITA, S_DIVB, S_WAITB, S_COEF_C,
    S_T_MUL, S_T_ACC, S_T_ADD, S_ODD_SAVE, S_S_MUL, S_S_ACC,
    S_DIVE, S_WAITE, S_EMIT_ODD, S_EMIT_EVEN, S_EMIT_ONE, S_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SPACING, OP_MUL_DD, OP_MUL_DH, OP_NUM,
    OP_DIV_A, OP_DIV_B, OP_DIV_E, OP_GET_A, OP_GET_B, OP_GET_E,
    OP_COEF_C, OP_T_MUL, OP_T_ACC, OP_T_ADD, OP_ODD_SAVE,
    OP_S_MUL, OP_S_ACC, OP_EMIT, OP_SHIFT
  } op_t;

  typedef enum logic [2:0] {
    RES_FIRST, RES_SECOND, RES_ODD, RES_EVEN, RES_BACK
  } res_t;

  typedef struct packed {
    op_t        op;
    logic       bwd;
    logic [1:0] sel;
    logic [1:0] limb;
    res_t       kind;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic n_odd;
    logic last;
    logic zero_spacing;
    logic div_done;
  } sts_t;

  function automatic logic signed [IW-1:0] sat64(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(64'sh7FFF_FFFF_FFFF_FFFF);
    lo = -hi - AW'(1);
    if (v > hi) return IW'(hi);
    else if (v < lo) return IW'(lo);
    else return IW'(v);
  endfunction

  function automatic logic signed [CW-1:0] clamp95(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(1) <<< 95;
    lo = -hi;
    if (v > hi) return CW'(hi);
    else if (v < lo) return CW'(lo);
    else return CW'(v);
  endfunction

endpackage

// File: sv/csn_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample items and result items
// depends on csn_pkg

interface csn_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [csn_pkg::XW-1:0]   abscissa;
  logic signed [csn_pkg::XW-1:0]   sample_value;
  logic                            last_sample;
  modport source (output valid, abscissa, sample_value, last_sample, input ready);
  modport sink   (input valid, abscissa, sample_value, last_sample, output ready);
endinterface

interface csn_out_if;
  logic                            valid;
  logic                            ready;
  logic [csn_pkg::IDXW-1:0]        point_index;
  logic signed [csn_pkg::IW-1:0]   integral;
  logic [csn_pkg::STW-1:0]         status;
  logic                            last_result;
  modport source (output valid, point_index, integral, status, last_result, input ready);
  modport sink   (input valid, point_index, integral, status, last_result, output ready);
endinterface

// File: sv/cumulative_simpson_nonuniform_core.sv
`timescale 1ns / 1ps
// top level of the cumulative simpson integrator over a nonuniform grid
// depends on csn_pkg, csn_if, csn_controller, csn_datapath

// Streams the running integral of a run of (abscissa, value) samples, Q16.16 in,
// Q32.32 saturating out. One result per even point, the odd point before it
// comes out just ahead of it, so an even point (from the third on) gives two
// results; a final odd point gives one via the backward form. With zero
// spacing the coefficient work is skipped. The arithmetic is done by the
// shared divider (two quotient bits per cycle, two coefficient divisions), by
// the single 33x33 multiplier that builds each coefficient-times-value term
// from three limb products and by the divide by six of the even-point mix (16
// bits per cycle). Items are taken one at a time; a finished result may wait
// in the output register while the next item is accepted, and a stalled
// output holds the sequencer only when a new result is due.

module cumulative_simpson_nonuniform_core #(
  parameter int MAX_POINTS = csn_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = csn_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  csn_in_if.sink      in_ch,
  csn_out_if.source   out_ch
);

  // command and status between sequencer and datapath
  csn_pkg::cmd_t cmd;
  csn_pkg::sts_t sts;

  // sequencer owns both handshakes
  csn_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds run state and drives the result payload
  csn_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_abscissa     (in_ch.abscissa),
    .in_sample_value (in_ch.sample_value),
    .in_last_sample  (in_ch.last_sample),
    .out_point_index (out_ch.point_index),
    .out_integral    (out_ch.integral),
    .out_status      (out_ch.status),
    .out_last_result (out_ch.last_result)
  );

endmodule

// File: sv/csn_divider.sv
`timescale 1ns / 1ps
// signed restoring divider, two quotient bits per cycle, truncating toward zero
// depends on nothing outside itself

module csn_divider #(
  parameter int NW = 100,
  parameter int DW = 37
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW:0]   dividend,
  input  logic signed [DW:0]   divisor,
  output logic                 done,
  output logic signed [NW:0]   quotient
);

  localparam int ITER = NW / 2;
  localparam int CNW  = $clog2(ITER + 1);

  logic [NW-1:0]  nm_r;
  logic [NW-1:0]  q_r;
  logic [DW-1:0]  dm_r;
  logic [DW-1:0]  rem_r;
  logic           neg_r;
  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;

  logic [DW:0]    r1, r2;
  logic [DW-1:0]  rem1, rem2;
  logic           qb1, qb2;
  logic [NW:0]    nabs;
  logic [DW:0]    dabs;

  always_comb begin
    nabs = dividend[NW] ? (NW+1)'(-dividend) : (NW+1)'(dividend);
    dabs = divisor[DW]  ? (DW+1)'(-divisor)  : (DW+1)'(divisor);
    r1   = {rem_r, nm_r[NW-1]};
    qb1  = (r1 >= {1'b0, dm_r});
    rem1 = qb1 ? DW'(r1 - {1'b0, dm_r}) : DW'(r1);
    r2   = {rem1, nm_r[NW-2]};
    qb2  = (r2 >= {1'b0, dm_r});
    rem2 = qb2 ? DW'(r2 - {1'b0, dm_r}) : DW'(r2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNW'(ITER);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nm_r  <= nabs[NW-1:0];
      dm_r  <= dabs[DW-1:0];
      neg_r <= dividend[NW] ^ divisor[DW];
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      nm_r  <= {nm_r[NW-3:0], 2'b00};
      rem_r <= rem2;
      q_r   <= {q_r[NW-3:0], qb1, qb2};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// File: sv/csn_datapath.sv
`timescale 1ns / 1ps
// datapath: point history, running sums, coefficient and term arithmetic, result register
// depends on csn_pkg and csn_divider

module csn_datapath #(
  parameter int MAX_POINTS = csn_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = csn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csn_pkg::cmd_t                     cmd,
  output csn_pkg::sts_t                     sts,
  input  logic signed [csn_pkg::XW-1:0]     in_abscissa,
  input  logic signed [csn_pkg::XW-1:0]     in_sample_value,
  input  logic                              in_last_sample,
  output logic [csn_pkg::IDXW-1:0]          out_point_index,
  output logic signed [csn_pkg::IW-1:0]     out_integral,
  output logic [csn_pkg::STW-1:0]           out_status,
  output logic                              out_last_result
);

  localparam int XW   = csn_pkg::XW;
  localparam int IW   = csn_pkg::IW;
  localparam int MW   = csn_pkg::MW;
  localparam int PW   = csn_pkg::PW;
  localparam int CW   = csn_pkg::CW;
  localparam int AW   = csn_pkg::AW;
  localparam int CNTW = $clog2(MAX_POINTS);
  localparam int TSH  = 2 * FRAC_BITS;
  localparam int QSR  = (TSH >= 32) ? TSH - 32 : 0;
  localparam int QSL  = (TSH < 32) ? 32 - TSH : 0;
  localparam int SUMW = PW + QSL + 2;
  localparam int DNW  = csn_pkg::DIV_NW + 1;
  localparam int DDW  = csn_pkg::DIV_DW + 1;
  // divide by six of the even-point mix, 16 bits per cycle
  localparam int EW      = IW + 3;
  localparam int EPW     = 80;
  localparam int E_STEPS = EPW / 16;
  localparam logic [19:0] RECIP6 = 20'd699051;  // ceil(2^22 / 6)

  // run state
  logic signed [XW-1:0] older_x_r, older_f_r, prev_x_r, prev_f_r;
  logic signed [IW-1:0] fine_r, coarse_r, even_r;
  logic [CNTW-1:0]      n_r;
  // working registers
  logic signed [XW-1:0] cur_x_r, cur_f_r;
  logic                 cur_last_r;
  logic signed [MW-1:0] d_r, h_r;
  logic                 zero_r, bwd_r;
  logic signed [PW-1:0] prod_r, dd_r, dh_r;
  logic signed [CW-1:0] a_r, b_r, c_r;
  logic signed [AW-1:0] acc_r, tacc_r;
  logic signed [IW-1:0] odd_val_r;
  logic [csn_pkg::STW-1:0] odd_st_r;
  // result register
  logic [csn_pkg::IDXW-1:0] idx_r;
  logic signed [IW-1:0]     val_r;
  logic [csn_pkg::STW-1:0]  st_r;
  logic                     lastres_r;
  // divide-by-six unit
  logic [EPW-1:0]       e_m_r;
  logic [EW-1:0]        e_q_r;
  logic [2:0]           e_rem_r;
  logic                 e_neg_r, e_busy_r, e_done_r;
  logic [2:0]           e_cnt_r;

  logic signed [MW-1:0]  ma, mb, sp_d, sp_h;
  logic signed [PW-1:0]  mul_p;
  logic signed [CW-1:0]  coef;
  logic signed [XW-1:0]  fsel;
  logic                  div_start, div_done;
  logic signed [DNW-1:0] div_num, div_q;
  logic signed [DDW-1:0] div_den;
  logic signed [SUMW-1:0] s_q, s_sum;
  logic signed [IW-1:0]  s_base;
  logic signed [AW-1:0]  t_part;
  logic signed [EW-1:0]  e_num;
  logic [EW-1:0]         e_mag;
  logic [18:0]           e_t;
  logic [37:0]           e_prod;
  logic [15:0]           e_qd;
  logic [2:0]            e_rd;
  logic signed [EW:0]    e_quot;

  // spacing and coefficient / value selection
  always_comb begin
    if (cmd.bwd) begin
      sp_h = MW'(prev_x_r) - MW'(older_x_r);
      sp_d = MW'(cur_x_r) - MW'(prev_x_r);
    end else begin
      sp_d = MW'(prev_x_r) - MW'(older_x_r);
      sp_h = MW'(cur_x_r) - MW'(prev_x_r);
    end
    case (cmd.sel)
      2'd0:    begin coef = bwd_r ? c_r : a_r; fsel = older_f_r; end
      2'd1:    begin coef = b_r;               fsel = prev_f_r;  end
      default: begin coef = bwd_r ? a_r : c_r; fsel = cur_f_r;   end
    endcase
  end

  // single shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      csn_pkg::OP_MUL_DD: begin ma = d_r; mb = d_r; end
      csn_pkg::OP_MUL_DH: begin ma = d_r; mb = h_r; end
      csn_pkg::OP_T_MUL: begin
        case (cmd.limb)
          2'd0:    ma = $signed({1'b0, coef[31:0]});
          2'd1:    ma = $signed({1'b0, coef[63:32]});
          default: ma = coef[CW-1:64];
        endcase
        mb = MW'(fsel);
      end
      csn_pkg::OP_S_MUL: begin
        case (cmd.sel)
          2'd0: begin
            ma = MW'(older_f_r) + MW'(cur_f_r);
            mb = MW'(cur_x_r) - MW'(older_x_r);
          end
          2'd1: begin
            ma = MW'(older_f_r) + MW'(prev_f_r);
            mb = MW'(prev_x_r) - MW'(older_x_r);
          end
          default: begin
            ma = MW'(prev_f_r) + MW'(cur_f_r);
            mb = MW'(cur_x_r) - MW'(prev_x_r);
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mul_p = PW'(ma) * PW'(mb);
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      csn_pkg::OP_DIV_A: begin
        div_start = 1'b1;
        div_num   = DNW'(((DNW'(dd_r) <<< 1) + DNW'(dh_r) * DNW'(3)) <<< 32);
        div_den   = DDW'((DDW'(d_r) + DDW'(h_r)) * DDW'(6));
      end
      csn_pkg::OP_DIV_B: begin
        div_start = 1'b1;
        div_num   = DNW'((DNW'(dd_r) + DNW'(dh_r) * DNW'(3)) <<< 32);
        div_den   = DDW'(DDW'(h_r) * DDW'(6));
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // trapezoid update and term partial product placement
  always_comb begin
    s_base = (cmd.sel == 2'd0) ? coarse_r : fine_r;
    s_q    = (SUMW'(prod_r) <<< QSL) >>> QSR;
    s_sum  = SUMW'(s_base) + s_q;
    case (cmd.limb)
      2'd0:    t_part = AW'(prod_r);
      2'd1:    t_part = AW'(prod_r) <<< 32;
      default: t_part = AW'(prod_r) <<< 64;
    endcase
  end

  // even-point mix divided by six: long division on 16-bit digits,
  // each digit by reciprocal multiplication, remainder carried on
  always_comb begin
    e_num  = (EW'(fine_r) <<< 2) - EW'(coarse_r);
    e_mag  = e_num[EW-1] ? EW'(-e_num) : EW'(e_num);
    e_t    = {e_rem_r, e_m_r[EPW-1 -: 16]};
    e_prod = 38'(e_t) * 38'(RECIP6);
    e_qd   = e_prod[37:22];
    e_rd   = 3'(e_t - (19'(e_qd) * 19'd6));
    e_quot = e_neg_r ? -$signed({1'b0, e_q_r}) : $signed({1'b0, e_q_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_busy_r <= 1'b0;
      e_done_r <= 1'b0;
      e_cnt_r  <= '0;
    end else if (cmd.op == csn_pkg::OP_DIV_E) begin
      e_busy_r <= 1'b1;
      e_done_r <= 1'b0;
      e_cnt_r  <= 3'(E_STEPS);
    end else if (e_busy_r) begin
      e_cnt_r <= e_cnt_r - 3'd1;
      if (e_cnt_r == 3'd1) begin
        e_busy_r <= 1'b0;
        e_done_r <= 1'b1;
      end
    end else begin
      e_done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == csn_pkg::OP_DIV_E) begin
      e_m_r   <= EPW'(e_mag);
      e_rem_r <= '0;
      e_q_r   <= '0;
      e_neg_r <= e_num[EW-1];
    end else if (e_busy_r) begin
      e_m_r   <= {e_m_r[EPW-17:0], 16'h0000};
      e_rem_r <= e_rd;
      e_q_r   <= {e_q_r[EW-17:0], e_qd};
    end
  end

  csn_divider #(.NW(csn_pkg::DIV_NW), .DW(csn_pkg::DIV_DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // run state, cleared by reset and at the end of a run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_x_r <= '0;
      older_f_r <= '0;
      prev_x_r  <= '0;
      prev_f_r  <= '0;
      fine_r    <= '0;
      coarse_r  <= '0;
      even_r    <= '0;
      n_r       <= '0;
    end else begin
      case (cmd.op)
        csn_pkg::OP_S_ACC: begin
          if (cmd.sel == 2'd0) coarse_r <= csn_pkg::sat64(AW'(s_sum));
          else                 fine_r   <= csn_pkg::sat64(AW'(s_sum));
        end
        csn_pkg::OP_GET_E: even_r <= csn_pkg::sat64(AW'(e_quot));
        csn_pkg::OP_SHIFT: begin
          if (cur_last_r) begin
            older_x_r <= '0;
            older_f_r <= '0;
            prev_x_r  <= '0;
            prev_f_r  <= '0;
            fine_r    <= '0;
            coarse_r  <= '0;
            even_r    <= '0;
            n_r       <= '0;
          end else begin
            older_x_r <= prev_x_r;
            older_f_r <= prev_f_r;
            prev_x_r  <= cur_x_r;
            prev_f_r  <= cur_f_r;
            n_r       <= n_r + CNTW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      csn_pkg::OP_LOAD: begin
        cur_x_r    <= in_abscissa;
        cur_f_r    <= in_sample_value;
        cur_last_r <= in_last_sample | (n_r == CNTW'(MAX_POINTS - 1));
      end
      csn_pkg::OP_SPACING: begin
        d_r    <= sp_d;
        h_r    <= sp_h;
        bwd_r  <= cmd.bwd;
        zero_r <= (sp_d == '0) || (sp_h == '0) || ((MW'(sp_d) + MW'(sp_h)) == '0)
                  || (((MW+1)'(sp_d) + (MW+1)'(sp_h)) == '0);
      end
      csn_pkg::OP_MUL_DD: prod_r <= mul_p;
      csn_pkg::OP_MUL_DH: begin
        dd_r   <= prod_r;
        prod_r <= mul_p;
      end
      csn_pkg::OP_NUM:   dh_r <= prod_r;
      csn_pkg::OP_GET_A: a_r  <= csn_pkg::clamp95(AW'(div_q));
      csn_pkg::OP_GET_B: b_r  <= csn_pkg::clamp95(AW'(div_q));
      csn_pkg::OP_COEF_C: begin
        c_r    <= csn_pkg::clamp95((AW'(d_r) <<< 32) - AW'(a_r) - AW'(b_r));
        acc_r  <= AW'(even_r);
        tacc_r <= '0;
      end
      csn_pkg::OP_T_MUL: prod_r <= mul_p;
      csn_pkg::OP_T_ACC: tacc_r <= tacc_r + t_part;
      csn_pkg::OP_T_ADD: begin
        acc_r  <= acc_r + (tacc_r >>> TSH);
        tacc_r <= '0;
      end
      csn_pkg::OP_ODD_SAVE: begin
        if (zero_r) begin
          odd_val_r <= even_r;
          odd_st_r  <= csn_pkg::STAT_ZERO;
        end else begin
          odd_val_r <= csn_pkg::sat64(acc_r);
          odd_st_r  <= csn_pkg::STAT_OK;
        end
      end
      csn_pkg::OP_S_MUL: prod_r <= mul_p;
      csn_pkg::OP_EMIT: begin
        case (cmd.kind)
          csn_pkg::RES_FIRST: begin
            idx_r     <= '0;
            val_r     <= '0;
            st_r      <= cur_last_r ? csn_pkg::STAT_SHORT : csn_pkg::STAT_OK;
            lastres_r <= cur_last_r;
          end
          csn_pkg::RES_SECOND: begin
            idx_r     <= 16'd1;
            val_r     <= '0;
            st_r      <= csn_pkg::STAT_SHORT;
            lastres_r <= 1'b1;
          end
          csn_pkg::RES_ODD: begin
            idx_r     <= 16'(n_r - CNTW'(1));
            val_r     <= odd_val_r;
            st_r      <= odd_st_r;
            lastres_r <= 1'b0;
          end
          csn_pkg::RES_EVEN: begin
            idx_r     <= 16'(n_r);
            val_r     <= even_r;
            st_r      <= csn_pkg::STAT_OK;
            lastres_r <= cur_last_r;
          end
          default: begin
            idx_r     <= 16'(n_r);
            val_r     <= odd_val_r;
            st_r      <= odd_st_r;
            lastres_r <= 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.n_zero       = (n_r == '0);
    sts.n_one        = (n_r == CNTW'(1));
    sts.n_odd        = n_r[0];
    sts.last         = cur_last_r;
    sts.zero_spacing = zero_r;
    sts.div_done     = div_done | e_done_r;
  end

  assign out_point_index = idx_r;
  assign out_integral    = val_r;
  assign out_status      = st_r;
  assign out_last_result = lastres_r;

endmodule

// File: sv/csn_controller.sv
`timescale 1ns / 1ps
// sequencer: walks one point through load, coefficients, terms, sums and result delivery
// depends on csn_pkg

module csn_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  csn_pkg::sts_t  sts,
  output csn_pkg::cmd_t  cmd
);

  csn_pkg::state_t state_r, state_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [1:0]      limb_r, limb_nxt;
  csn_pkg::res_t   kind_r, kind_nxt;
  logic            bwd_r, bwd_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;
  logic            emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csn_pkg::S_IDLE;
      sel_r       <= '0;
      limb_r      <= '0;
      kind_r      <= csn_pkg::RES_FIRST;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      limb_r      <= limb_nxt;
      kind_r      <= kind_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    limb_nxt  = limb_r;
    kind_nxt  = kind_r;
    bwd_nxt   = bwd_r;
    in_ready  = 1'b0;
    emit      = 1'b0;
    slot_free = !out_valid_r || out_ready;
    cmd.op    = csn_pkg::OP_NONE;
    cmd.bwd   = bwd_r;
    cmd.sel   = sel_r;
    cmd.limb  = limb_r;
    cmd.kind  = kind_r;
    case (state_r)
      csn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = csn_pkg::OP_LOAD;
          state_nxt = csn_pkg::S_DISPATCH;
        end
      end
      csn_pkg::S_DISPATCH: begin
        if (sts.n_zero) begin
          kind_nxt  = csn_pkg::RES_FIRST;
          state_nxt = csn_pkg::S_EMIT_ONE;
        end else if (sts.n_one) begin
          kind_nxt  = csn_pkg::RES_SECOND;
          state_nxt = sts.last ? csn_pkg::S_EMIT_ONE : csn_pkg::S_FINISH;
        end else if (!sts.n_odd) begin
          bwd_nxt   = 1'b0;
          state_nxt = csn_pkg::S_SPC;
        end else if (sts.last) begin
          bwd_nxt   = 1'b1;
          state_nxt = csn_pkg::S_SPC;
        end else begin
          state_nxt = csn_pkg::S_FINISH;
        end
      end
      csn_pkg::S_SPC: begin
        cmd.op    = csn_pkg::OP_SPACING;
        state_nxt = csn_pkg::S_M_DD;
      end
      csn_pkg::S_M_DD: begin
        if (sts.zero_spacing) begin
          state_nxt = csn_pkg::S_ODD_SAVE;
        end else begin
          cmd.op    = csn_pkg::OP_MUL_DD;
          state_nxt = csn_pkg::S_M_DH;
        end
      end
      csn_pkg::S_M_DH: begin
        cmd.op    = csn_pkg::OP_MUL_DH;
        state_nxt = csn_pkg::S_NUM;
      end
      csn_pkg::S_NUM: begin
        cmd.op    = csn_pkg::OP_NUM;
        state_nxt = csn_pkg::S_DIVA;
      end
      csn_pkg::S_DIVA: begin
        cmd.op    = csn_pkg::OP_DIV_A;
        state_nxt = csn_pkg::S_WAITA;
      end
      csn_pkg::S_WAITA: begin
        if (sts.div_done) begin
          cmd.op    = csn_pkg::OP_GET_A;
          state_nxt = csn_pkg::S_DIVB;
        end
      end
      csn_pkg::S_DIVB: begin
        cmd.op    = csn_pkg::OP_DIV_B;
        state_nxt = csn_pkg::S_WAITB;
      end
      csn_pkg::S_WAITB: begin
        if (sts.div_done) begin
          cmd.op    = csn_pkg::OP_GET_B;
          state_nxt = csn_pkg::S_COEF_C;
        end
      end
      csn_pkg::S_COEF_C: begin
        cmd.op    = csn_pkg::OP_COEF_C;
        sel_nxt   = '0;
        limb_nxt  = '0;
        state_nxt = csn_pkg::S_T_MUL;
      end
      csn_pkg::S_T_MUL: begin
        cmd.op    = csn_pkg::OP_T_MUL;
        state_nxt = csn_pkg::S_T_ACC;
      end
      csn_pkg::S_T_ACC: begin
        cmd.op = csn_pkg::OP_T_ACC;
        if (limb_r == 2'd2) begin
          limb_nxt  = '0;
          state_nxt = csn_pkg::S_T_ADD;
        end else begin
          limb_nxt  = limb_r + 2'd1;
          state_nxt = csn_pkg::S_T_MUL;
        end
      end
      csn_pkg::S_T_ADD: begin
        cmd.op = csn_pkg::OP_T_ADD;
        if (sel_r == 2'd2) begin
          state_nxt = csn_pkg::S_ODD_SAVE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = csn_pkg::S_T_MUL;
        end
      end
      csn_pkg::S_ODD_SAVE: begin
        cmd.op  = csn_pkg::OP_ODD_SAVE;
        sel_nxt = '0;
        if (bwd_r) begin
          kind_nxt  = csn_pkg::RES_BACK;
          state_nxt = csn_pkg::S_EMIT_ONE;
        end else begin
          state_nxt = csn_pkg::S_S_MUL;
        end
      end
      csn_pkg::S_S_MUL: begin
        cmd.op    = csn_pkg::OP_S_MUL;
        state_nxt = csn_pkg::S_S_ACC;
      end
      csn_pkg::S_S_ACC: begin
        cmd.op = csn_pkg::OP_S_ACC;
        if (sel_r == 2'd2) begin
          state_nxt = csn_pkg::S_DIVE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = csn_pkg::S_S_MUL;
        end
      end
      csn_pkg::S_DIVE: begin
        cmd.op    = csn_pkg::OP_DIV_E;
        state_nxt = csn_pkg::S_WAITE;
      end
      csn_pkg::S_WAITE: begin
        if (sts.div_done) begin
          cmd.op    = csn_pkg::OP_GET_E;
          state_nxt = csn_pkg::S_EMIT_ODD;
        end
      end
      csn_pkg::S_EMIT_ODD: begin
        if (slot_free) begin
          cmd.op    = csn_pkg::OP_EMIT;
          cmd.kind  = csn_pkg::RES_ODD;
          emit      = 1'b1;
          state_nxt = csn_pkg::S_EMIT_EVEN;
        end
      end
      csn_pkg::S_EMIT_EVEN: begin
        if (slot_free) begin
          cmd.op    = csn_pkg::OP_EMIT;
          cmd.kind  = csn_pkg::RES_EVEN;
          emit      = 1'b1;
          state_nxt = csn_pkg::S_FINISH;
        end
      end
      csn_pkg::S_EMIT_ONE: begin
        if (slot_free) begin
          cmd.op    = csn_pkg::OP_EMIT;
          emit      = 1'b1;
          state_nxt = csn_pkg::S_FINISH;
        end
      end
      csn_pkg::S_FINISH: begin
        cmd.op    = csn_pkg::OP_SHIFT;
        state_nxt = csn_pkg::S_IDLE;
      end
      default: begin
        state_nxt = csn_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || emit;
  end

  assign out_valid = out_valid_r;

  // result register is only overwritten once its previous item has gone
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == csn_pkg::OP_EMIT) |-> (!out_valid_r || out_ready))
    else $error("result overwritten while still waiting");

  // every accepted item is dispatched on the next cycle
  a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csn_pkg::S_IDLE && in_valid) |=> (state_r == csn_pkg::S_DISPATCH))
    else $error("accepted item not dispatched");

  // the end of a run returns the point counter to zero
  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csn_pkg::S_FINISH && sts.last) |=> sts.n_zero)
    else $error("point counter not cleared after last point");

endmodule
